/* rtl/core/ssp_frame_builder_unit_macros.svh */
// Assertion macros for the SSP frame builder.
// Used by the top level only; no other dependencies.
`ifndef SSP_FRAME_BUILDER_UNIT_MACROS_SVH
`define SSP_FRAME_BUILDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SSPFB_ASSERT_NOW(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SSPFB_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SSPFB_ASSERT_NOW(label, expr, msg)
`define SSPFB_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* rtl/core/ssp_fb_pkg.sv */
// Shared types, constants and the CRC-16 step for the SSP frame builder.
// No dependencies.
package ssp_fb_pkg;

	localparam logic [1:0] OP_FRAME  = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_INVERT = 2'd2;

	localparam logic [7:0]  STX_BYTE = 8'h7F;
	localparam logic [7:0]  SEQ_SET  = 8'h80;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	localparam int FB_QUEUE_DEPTH = 2;

	// Slot numbers of the up to eight bytes one body byte can produce.
	localparam logic [2:0] SLOT_STX     = 3'd0;
	localparam logic [2:0] SLOT_SEQ     = 3'd1;
	localparam logic [2:0] SLOT_DATA    = 3'd2;
	localparam logic [2:0] SLOT_DATA_DUP = 3'd3;
	localparam logic [2:0] SLOT_CRCL    = 3'd4;
	localparam logic [2:0] SLOT_CRCL_DUP = 3'd5;
	localparam logic [2:0] SLOT_CRCH    = 3'd6;
	localparam logic [2:0] SLOT_CRCH_DUP = 3'd7;

	// One body byte after classification, with the CRC that includes it.
	typedef struct packed {
		logic        hdr;
		logic        seq;
		logic [7:0]  data;
		logic        last;
		logic [15:0] crc;
	} ssp_fb_entry_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// CRC after the sequence byte, for either value of the sequence bit.
	localparam logic [15:0] CRC_START0 = crc_fold(CRC_SEED, 8'h00);
	localparam logic [15:0] CRC_START1 = crc_fold(CRC_SEED, SEQ_SET);

endpackage

/* rtl/core/ssp_fb_front.sv */
// Front end of the SSP frame builder: takes input beats, tracks sequence bit,
// frame state and CRC, and pushes one entry per body byte. Uses ssp_fb_pkg.
module ssp_fb_front import ssp_fb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    op,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic          q_full,
	output logic          q_push,
	output ssp_fb_entry_t q_entry
);

	logic        seq_q;
	logic        in_frame_q;
	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [15:0] crc_new;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (op == OP_FRAME);

	// A new frame starts from the CRC over its sequence byte.
	assign crc_base = in_frame_q ? crc_q : (seq_q ? CRC_START1 : CRC_START0);
	assign crc_new  = crc_fold(crc_base, data_byte);

	assign q_entry.hdr  = !in_frame_q;
	assign q_entry.seq  = seq_q;
	assign q_entry.data = data_byte;
	assign q_entry.last = last_byte;
	assign q_entry.crc  = crc_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= 1'b0;
			in_frame_q <= 1'b0;
			crc_q      <= CRC_SEED;
		end else if (accept) begin
			case (op)
				OP_FRAME: begin
					if (!in_frame_q) begin
						seq_q <= ~seq_q;
					end
					in_frame_q <= !last_byte;
					crc_q      <= last_byte ? CRC_SEED : crc_new;
				end
				OP_CLEAR:  seq_q <= 1'b0;
				OP_INVERT: seq_q <= ~seq_q;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/ssp_fb_queue.sv */
// Short FIFO of classified entries between front and back of the frame builder.
// Uses ssp_fb_pkg for the entry type.
module ssp_fb_queue import ssp_fb_pkg::*; #(
	parameter int DEPTH = FB_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssp_fb_entry_t wr_entry,
	input  logic          pop,
	output ssp_fb_entry_t rd_entry,
	output logic          full,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	ssp_fb_entry_t    mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/ssp_fb_back.sv */
// Back end of the SSP frame builder: walks the byte slots of the head entry,
// one wire byte per cycle while out_ready allows, into the output register. Uses ssp_fb_pkg.
module ssp_fb_back import ssp_fb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ssp_fb_entry_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          frame_end
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       frame_end_q;

	logic [7:0] en;
	logic [7:0] avail;
	logic [2:0] sel;
	logic       found;
	logic       more;
	logic       load;
	logic [7:0] slot_byte;

	// Slots that this entry actually emits; 0x7F bytes get a second copy.
	always_comb begin
		en[SLOT_STX]      = head.hdr;
		en[SLOT_SEQ]      = head.hdr;
		en[SLOT_DATA]     = 1'b1;
		en[SLOT_DATA_DUP] = (head.data == STX_BYTE);
		en[SLOT_CRCL]     = head.last;
		en[SLOT_CRCL_DUP] = head.last && (head.crc[7:0] == STX_BYTE);
		en[SLOT_CRCH]     = head.last;
		en[SLOT_CRCH_DUP] = head.last && (head.crc[15:8] == STX_BYTE);
	end

	assign avail = en & (8'hFF << idx_q);

	always_comb begin
		sel   = SLOT_STX;
		found = 1'b0;
		more  = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (avail[i]) begin
				if (found) begin
					more = 1'b1;
				end else begin
					sel   = 3'(i);
					found = 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (sel)
			SLOT_STX:                 slot_byte = STX_BYTE;
			SLOT_SEQ:                 slot_byte = head.seq ? SEQ_SET : 8'h00;
			SLOT_DATA, SLOT_DATA_DUP: slot_byte = head.data;
			SLOT_CRCL, SLOT_CRCL_DUP: slot_byte = head.crc[7:0];
			default:                  slot_byte = head.crc[15:8];
		endcase
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && !more;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= slot_byte;
			run_last_q  <= !more;
			frame_end_q <= !more && head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= more ? sel + 3'd1 : 3'd0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

endmodule

/* rtl/core/ssp_frame_builder_unit.sv */
// SSP frame builder top level: front end, entry queue and byte emitter.
// Depends on ssp_fb_pkg, ssp_fb_front, ssp_fb_queue, ssp_fb_back and the macros header.
//
// Usage: input beats carry op, data_byte and last_byte on in_valid/in_ready.
// op 0 is a body byte; ops 1 and 2 clear or invert the sequence bit and give
// no output; op 3 is ignored. Output beats carry one wire byte each on
// out_valid/out_ready, with run_last on the final byte caused by an input beat
// and frame_end on the final CRC byte of a frame.
// A body byte gives 1 to 8 output bytes: STX and sequence byte when it opens a
// frame, the byte itself, and the CRC low then high when it closes one; every
// 0x7F after the STX is sent twice.
// The first output byte of an accepted input beat passes through the queue and
// then the output register before out_valid rises.
// Throughput: one output byte per cycle, set by the back-end emitter, while the queue
// holds an entry and the receiver takes each byte; an entry is popped after its
// last byte. Input beats are taken every cycle while the two-entry queue has room.
// Reset clears the sequence bit, the frame state, the CRC and the queue.
// When the receiver stalls, the output byte holds, the queue fills, and then
// in_ready drops.
`include "ssp_frame_builder_unit_macros.svh"
module ssp_frame_builder_unit import ssp_fb_pkg::*; #(
	parameter int QUEUE_DEPTH = FB_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	ssp_fb_entry_t push_entry;
	ssp_fb_entry_t head_entry;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;

	ssp_fb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	ssp_fb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (push_entry),
		.pop      (q_pop),
		.rd_entry (head_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	ssp_fb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_entry),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

	`SSPFB_ASSERT_NOW(a_fend_closes_run, !(out_valid && frame_end) || run_last, "fend w/o run_last")
	`SSPFB_ASSERT_NOW(a_queue_sane, !(q_full && q_empty), "queue both full and empty")
	`SSPFB_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid, "run gap")

endmodule
